// ----- hw/rtl/scf_pkg.sv -----
// ----------------------------------------------------------------------------
// scf_pkg: shared types and constants of the sphere contact force block
// Register indexes, fixed field widths and the sequencer state encoding.
// ----------------------------------------------------------------------------
package scf_pkg;

  // Fixed widths of the radius and stiffness registers.
  localparam int RADIUS_BITS = 18;
  localparam int STIFF_BITS  = 16;

  // Millinewton scaling: force in mN = N/m * um / 1000.
  localparam int MILLI_DIV  = 1000;
  localparam int MILLI_BITS = 10;

  // Configuration port index width and register indexes.
  localparam int CFG_IDX_BITS = 3;
  localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_X       = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_Y       = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_Z       = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_CONTACT_RADIUS = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_STIFFNESS      = 3'd4;

  // Reset values of the radius and stiffness registers.
  localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = 18'd35000;
  localparam logic [STIFF_BITS-1:0]  STIFF_RESET  = 16'd1000;

  // Shared multiplier: the A operand is wide enough for pen*stiffness, B holds an 18-bit value.
  localparam int MUL_A_W = RADIUS_BITS + STIFF_BITS;
  localparam int MUL_B_W = RADIUS_BITS;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // Sum of three squares of values below 2^18.
  localparam int SUMSQ_W = 2 * RADIUS_BITS + 2;
  // Denominator length * 1000 with length below 2^18.
  localparam int DEN_W   = RADIUS_BITS + MILLI_BITS;

  typedef enum logic [11:0] {
    S_IDLE = 12'b0000_0000_0001,
    S_ABS  = 12'b0000_0000_0010,
    S_SQ   = 12'b0000_0000_0100,
    S_SQRT = 12'b0000_0000_1000,
    S_LEN  = 12'b0000_0001_0000,
    S_PS   = 12'b0000_0010_0000,
    S_DEN  = 12'b0000_0100_0000,
    S_NUM  = 12'b0000_1000_0000,
    S_DCHK = 12'b0001_0000_0000,
    S_DIV  = 12'b0010_0000_0000,
    S_FIN  = 12'b0100_0000_0000,
    S_OUT  = 12'b1000_0000_0000
  } scf_state_t;

endpackage

// ----- hw/rtl/sphere_contact_force.sv -----
// ----------------------------------------------------------------------------
// sphere_contact_force: penalty force of a tool pressing into a fixed sphere
// Iterative fixed-point datapath around one shared multiplier and a
// shift/subtract unit, run by a one-hot sequencer.
// ----------------------------------------------------------------------------
// Usage. Each input item on the in_ stream is one tool position sample
// (pos_x, pos_y, pos_z in micrometres). For every item exactly one result
// item leaves on the out_ stream: the force vector in millinewtons, the
// contact flag, the safety latch state and a saturation flag.
// The block works on one item at a time; in_tready is high only while it is
// idle. A far offset (some axis at or beyond the radius) goes straight to
// result packing, and a sample with no contact once the length is known
// skips the force arithmetic. The length takes 19 square-root steps, and
// each force component that is not clamped takes one restoring division of
// FORCE_BITS - 1 steps; a component that saturates skips its division.
// The result stays in the output register until out_tready is high; while
// the receiver stalls no new item is taken. The block is ready again in the
// cycle after the result is taken.
// Reset (rst_n low, synchronous) drops out_tvalid, returns the sequencer to
// idle, loads the register defaults and arms the safety latch, which holds
// the force at zero until the first sample without contact. A register write
// takes effect at once, so registers are to be written only while no item is
// in flight; this is a rule for the user, and the block does not enforce it.
// ----------------------------------------------------------------------------
module sphere_contact_force #(
  parameter int POS_BITS   = 19,
  parameter int FORCE_BITS = 21,
  localparam int IN_W  = ((3 * POS_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((3 * FORCE_BITS + 3 + 7) / 8) * 8,
  localparam int CFG_W = (POS_BITS > scf_pkg::RADIUS_BITS) ? POS_BITS : scf_pkg::RADIUS_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input stream. tdata: pos_x, pos_y, pos_z (POS_BITS each, signed), zero pad.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [IN_W-1:0]                   in_tdata,
  // Result stream. tdata: force_x, force_y, force_z (FORCE_BITS each,
  // signed), in_contact, output_enabled, saturated, zero pad.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [OUT_W-1:0]                  out_tdata,
  // Configuration write port.
  input  logic                              cfg_wr_en,
  input  logic [scf_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_W-1:0]                  cfg_wdata
);

  localparam int D_W   = POS_BITS + 1;
  localparam int MAG_W = (D_W > scf_pkg::RADIUS_BITS) ? D_W : scf_pkg::RADIUS_BITS;
  localparam int Q_W   = FORCE_BITS - 1;
  localparam int HI_W  = scf_pkg::PROD_W - Q_W;
  localparam int CMP_W = (HI_W > scf_pkg::DEN_W) ? HI_W : scf_pkg::DEN_W;
  localparam int CNT_W = $clog2(Q_W);
  localparam int RB    = scf_pkg::RADIUS_BITS;
  localparam int SW    = scf_pkg::SUMSQ_W;
  localparam int DW    = scf_pkg::DEN_W;

  localparam logic [SW-1:0]    SQRT_TOP   = SW'(1) << (SW - 2);
  localparam logic [CNT_W-1:0] DIV_LAST   = CNT_W'(Q_W - 1);
  localparam logic [1:0]       LAST_AXIS  = 2'd2;

  // Configuration registers.
  logic signed [POS_BITS-1:0] center_r [3];
  logic [RB-1:0]              radius_r;
  logic [scf_pkg::STIFF_BITS-1:0] stiff_r;

  // Sequencer and datapath registers.
  scf_pkg::scf_state_t state_r, state_nxt;
  logic                safety_r, safety_nxt;
  logic signed [D_W-1:0] d_r [3];
  logic signed [D_W-1:0] d_nxt [3];
  logic [MAG_W-1:0]    mag_r [3];
  logic [MAG_W-1:0]    mag_nxt [3];
  logic                neg_r [3];
  logic                neg_nxt [3];
  logic [1:0]          idx_r, idx_nxt;
  logic [SW-1:0]       acc_r, acc_nxt;
  logic [SW-1:0]       root_r, root_nxt;
  logic [SW-1:0]       bit_r, bit_nxt;
  logic [RB-1:0]       len_r, len_nxt;
  logic [RB-1:0]       pen_r, pen_nxt;
  logic                contact_r, contact_nxt;
  logic [scf_pkg::MUL_A_W-1:0] ps_r, ps_nxt;
  logic [DW-1:0]       den_r, den_nxt;
  logic [scf_pkg::PROD_W-1:0] num_r, num_nxt;
  logic [DW-1:0]       rem_r, rem_nxt;
  logic [Q_W-1:0]      nq_r, nq_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [Q_W-1:0]      q_r [3];
  logic [Q_W-1:0]      q_nxt [3];
  logic                sat_r, sat_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]    out_data_r, out_data_nxt;

  // Combinational helpers.
  logic signed [POS_BITS-1:0] pos [3];
  logic [D_W-1:0]      mag_abs [3];
  logic                far;
  logic [scf_pkg::MUL_A_W-1:0] mul_a;
  logic [scf_pkg::MUL_B_W-1:0] mul_b;
  logic [scf_pkg::PROD_W-1:0]  prod;
  logic [SW:0]         trial;
  logic [CMP_W-1:0]    num_hi;
  logic [DW:0]         shifted;
  logic                qbit;
  logic [FORCE_BITS-1:0] fmag [3];
  logic [FORCE_BITS-1:0] force_v [3];

  assign in_tready  = (state_r == scf_pkg::S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Unpack the sample and form the absolute offsets with the far test.
  always_comb begin
    far = 1'b0;
    for (int i = 0; i < 3; i++) begin
      pos[i]     = in_tdata[i*POS_BITS +: POS_BITS];
      mag_abs[i] = d_r[i][D_W-1] ? (~d_r[i] + D_W'(1)) : d_r[i];
      if (MAG_W'(mag_abs[i]) >= MAG_W'(radius_r)) begin
        far = 1'b1;
      end
    end
  end

  // Operand selection for the shared multiplier. The product is always
  // registered before it is used by a later step.
  always_comb begin
    unique case (state_r)
      scf_pkg::S_SQ: begin
        mul_a = scf_pkg::MUL_A_W'(mag_r[idx_r][RB-1:0]);
        mul_b = mag_r[idx_r][RB-1:0];
      end
      scf_pkg::S_PS: begin
        mul_a = scf_pkg::MUL_A_W'(stiff_r);
        mul_b = pen_r;
      end
      scf_pkg::S_DEN: begin
        mul_a = scf_pkg::MUL_A_W'(scf_pkg::MILLI_DIV);
        mul_b = len_r;
      end
      scf_pkg::S_NUM: begin
        mul_a = ps_r;
        mul_b = mag_r[idx_r][RB-1:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod = scf_pkg::PROD_W'(mul_a) * scf_pkg::PROD_W'(mul_b);
  end

  // Square-root step, division checks and one restoring division step.
  always_comb begin
    trial   = {1'b0, root_r} + {1'b0, bit_r};
    num_hi  = CMP_W'(num_r[scf_pkg::PROD_W-1:Q_W]);
    shifted = {rem_r, nq_r[Q_W-1]};
    qbit    = (shifted >= {1'b0, den_r});
  end

  // Signed force components; result packing zeroes them unless in contact with the latch released.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fmag[i]    = {1'b0, q_r[i]};
      force_v[i] = neg_r[i] ? (~fmag[i] + FORCE_BITS'(1)) : fmag[i];
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    safety_nxt    = safety_r;
    idx_nxt       = idx_r;
    acc_nxt       = acc_r;
    root_nxt      = root_r;
    bit_nxt       = bit_r;
    len_nxt       = len_r;
    pen_nxt       = pen_r;
    contact_nxt   = contact_r;
    ps_nxt        = ps_r;
    den_nxt       = den_r;
    num_nxt       = num_r;
    rem_nxt       = rem_r;
    nq_nxt        = nq_r;
    cnt_nxt       = cnt_r;
    sat_nxt       = sat_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    for (int i = 0; i < 3; i++) begin
      d_nxt[i]   = d_r[i];
      mag_nxt[i] = mag_r[i];
      neg_nxt[i] = neg_r[i];
      q_nxt[i]   = q_r[i];
    end

    unique case (state_r)
      scf_pkg::S_IDLE: begin
        if (in_tvalid) begin
          for (int i = 0; i < 3; i++) begin
            d_nxt[i] = $signed({pos[i][POS_BITS-1], pos[i]})
                     - $signed({center_r[i][POS_BITS-1], center_r[i]});
          end
          sat_nxt     = 1'b0;
          contact_nxt = 1'b0;
          state_nxt   = scf_pkg::S_ABS;
        end
      end

      scf_pkg::S_ABS: begin
        for (int i = 0; i < 3; i++) begin
          mag_nxt[i] = MAG_W'(mag_abs[i]);
          neg_nxt[i] = d_r[i][D_W-1];
        end
        idx_nxt   = '0;
        acc_nxt   = '0;
        state_nxt = far ? scf_pkg::S_FIN : scf_pkg::S_SQ;
      end

      // Multiply-accumulate of the three squared offsets.
      scf_pkg::S_SQ: begin
        acc_nxt = acc_r + prod[SW-1:0];
        if (idx_r == LAST_AXIS) begin
          root_nxt  = '0;
          bit_nxt   = SQRT_TOP;
          state_nxt = scf_pkg::S_SQRT;
        end else begin
          idx_nxt = idx_r + 2'd1;
        end
      end

      // One digit of the integer square root per cycle.
      scf_pkg::S_SQRT: begin
        if ({1'b0, acc_r} >= trial) begin
          acc_nxt  = acc_r - trial[SW-1:0];
          root_nxt = (root_r >> 1) + bit_r;
        end else begin
          root_nxt = root_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        if (bit_r[0]) begin
          state_nxt = scf_pkg::S_LEN;
        end
      end

      scf_pkg::S_LEN: begin
        contact_nxt = (root_r != '0) && (root_r < SW'(radius_r));
        len_nxt     = root_r[RB-1:0];
        pen_nxt     = radius_r - root_r[RB-1:0];
        state_nxt   = contact_nxt ? scf_pkg::S_PS : scf_pkg::S_FIN;
      end

      scf_pkg::S_PS: begin
        ps_nxt    = prod[scf_pkg::MUL_A_W-1:0];
        state_nxt = scf_pkg::S_DEN;
      end

      scf_pkg::S_DEN: begin
        den_nxt   = prod[DW-1:0];
        idx_nxt   = '0;
        state_nxt = scf_pkg::S_NUM;
      end

      scf_pkg::S_NUM: begin
        num_nxt   = prod;
        state_nxt = scf_pkg::S_DCHK;
      end

      // A quotient of 2^Q_W or more is clamped without dividing.
      scf_pkg::S_DCHK: begin
        if (num_hi >= CMP_W'(den_r)) begin
          q_nxt[idx_r] = '1;
          sat_nxt      = 1'b1;
          if (idx_r == LAST_AXIS) begin
            state_nxt = scf_pkg::S_FIN;
          end else begin
            idx_nxt   = idx_r + 2'd1;
            state_nxt = scf_pkg::S_NUM;
          end
        end else begin
          rem_nxt   = num_hi[DW-1:0];
          nq_nxt    = num_r[Q_W-1:0];
          cnt_nxt   = DIV_LAST;
          state_nxt = scf_pkg::S_DIV;
        end
      end

      // Restoring division: the dividend shifts out of nq_r as the quotient
      // shifts in.
      scf_pkg::S_DIV: begin
        rem_nxt = qbit ? (shifted[DW-1:0] - den_r) : shifted[DW-1:0];
        nq_nxt  = {nq_r[Q_W-2:0], qbit};
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          q_nxt[idx_r] = nq_nxt;
          if (idx_r == LAST_AXIS) begin
            state_nxt = scf_pkg::S_FIN;
          end else begin
            idx_nxt   = idx_r + 2'd1;
            state_nxt = scf_pkg::S_NUM;
          end
        end
      end

      // Safety latch update and result packing.
      scf_pkg::S_FIN: begin
        safety_nxt   = safety_r | ~contact_r;
        out_data_nxt = '0;
        for (int i = 0; i < 3; i++) begin
          out_data_nxt[i*FORCE_BITS +: FORCE_BITS] =
            (contact_r && safety_nxt) ? force_v[i] : '0;
        end
        out_data_nxt[3*FORCE_BITS]     = contact_r;
        out_data_nxt[3*FORCE_BITS + 1] = safety_nxt;
        out_data_nxt[3*FORCE_BITS + 2] = sat_r;
        out_valid_nxt = 1'b1;
        state_nxt     = scf_pkg::S_OUT;
      end

      scf_pkg::S_OUT: begin
        if (out_tready) begin
          out_valid_nxt = 1'b0;
          state_nxt     = scf_pkg::S_IDLE;
        end
      end

      default: begin
        out_valid_nxt = 1'b0;
        state_nxt     = scf_pkg::S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= scf_pkg::S_IDLE;
      safety_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      safety_r    <= safety_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    acc_r      <= acc_nxt;
    root_r     <= root_nxt;
    bit_r      <= bit_nxt;
    len_r      <= len_nxt;
    pen_r      <= pen_nxt;
    contact_r  <= contact_nxt;
    ps_r       <= ps_nxt;
    den_r      <= den_nxt;
    num_r      <= num_nxt;
    rem_r      <= rem_nxt;
    nq_r       <= nq_nxt;
    cnt_r      <= cnt_nxt;
    sat_r      <= sat_nxt;
    out_data_r <= out_data_nxt;
    for (int i = 0; i < 3; i++) begin
      d_r[i]   <= d_nxt[i];
      mag_r[i] <= mag_nxt[i];
      neg_r[i] <= neg_nxt[i];
      q_r[i]   <= q_nxt[i];
    end
  end

  // Configuration registers; writes to unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_r[0] <= '0;
      center_r[1] <= '0;
      center_r[2] <= '0;
      radius_r    <= scf_pkg::RADIUS_RESET;
      stiff_r     <= scf_pkg::STIFF_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        scf_pkg::REG_CENTER_X:       center_r[0] <= cfg_wdata[POS_BITS-1:0];
        scf_pkg::REG_CENTER_Y:       center_r[1] <= cfg_wdata[POS_BITS-1:0];
        scf_pkg::REG_CENTER_Z:       center_r[2] <= cfg_wdata[POS_BITS-1:0];
        scf_pkg::REG_CONTACT_RADIUS: radius_r    <= cfg_wdata[RB-1:0];
        scf_pkg::REG_STIFFNESS:      stiff_r     <= cfg_wdata[scf_pkg::STIFF_BITS-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- hw/rtl/scf_checker.sv -----
// ----------------------------------------------------------------------------
// scf_checker: port-level checks of the sphere contact force block
// Watches the stream ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
module scf_checker #(
  parameter int FORCE_BITS = 21,
  localparam int OUT_W = ((3 * FORCE_BITS + 3 + 7) / 8) * 8
) (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [OUT_W-1:0]                 out_tdata
);

  localparam int CONTACT_BIT = 3 * FORCE_BITS;
  localparam int ENABLE_BIT  = 3 * FORCE_BITS + 1;
  localparam int SAT_BIT     = 3 * FORCE_BITS + 2;

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // One item at a time: never ready for input while a result waits.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while a result is pending");

  // After an item is taken the block is busy in the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item accepted back to back");

  // While the safety latch holds, the force is zero.
  a_latch_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[ENABLE_BIT] |-> out_tdata[3*FORCE_BITS-1:0] == '0)
    else $error("force present while latch holds");

  // Clamping only happens on a contact.
  a_sat_contact: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[SAT_BIT] |-> out_tdata[CONTACT_BIT])
    else $error("saturation reported without contact");

endmodule

bind sphere_contact_force scf_checker #(
  .FORCE_BITS (FORCE_BITS)
) u_scf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
